// ----- design/bwsu_pkg.sv -----
// bwsu_pkg: shared types and constants for the bitmap word search unit
// no dependencies; imported by the controller, datapath and top level

package bwsu_pkg;

	// segment width and derived widths
	localparam int unsigned WORD_BITS = 64;
	localparam int unsigned LPW       = $clog2(WORD_BITS + 1);
	localparam int unsigned IDXW      = $clog2(WORD_BITS);

	localparam logic [LPW-1:0] WB_L = LPW'(WORD_BITS);

	// command codes
	typedef enum logic [2:0] {
		CMD_SET   = 3'd0,
		CMD_CLR   = 3'd1,
		CMD_TEST  = 3'd2,
		CMD_NEXT  = 3'd3,
		CMD_PRIOR = 3'd4,
		CMD_NTH   = 3'd5,
		CMD_SUB   = 3'd6,
		CMD_RSVD  = 3'd7
	} cmd_t;

	// request and response payloads
	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] position;
		logic [63:0] other_word;
		logic [31:0] other_base;
	} req_t;

	typedef struct packed {
		logic [31:0] found_index;
		logic        flag;
		logic        range_error;
	} rsp_t;

	// controller to datapath commands
	typedef struct packed {
		logic exec;
		logic start;
		logic step;
		logic load_res;
	} ctl_t;

	// datapath to controller status
	typedef struct packed {
		logic need_scan;
		logic scan_done;
	} sts_t;

endpackage

// ----- design/bitmap_word_search_unit_top.sv -----
// Bitmap word search unit: set, clear, test and subtract act on the 64-bit
// segment in the cycle of acceptance and give their response on the next
// cycle, so these run at one request per cycle while the response side keeps
// up. Next, prior and nth searches walk the segment one local position per
// cycle: the scanner takes its start point on acceptance, steps to the hit
// or the end of the window, and its result enters the response register in
// the finish state once that is free; requests are stalled meanwhile. A
// search starting out of range (next at or past base + 64, prior at or below
// base + 1, nth with zero count) answers at once like a bit op. The user
// must write base_index through cfg_we/cfg_wdata only while the unit is idle;
// this is not enforced. Depends on bwsu_pkg, bwsu_ctrl and bwsu_datapath.

module bitmap_word_search_unit_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [31:0]    cfg_wdata,
	input  logic           in_valid,
	output logic           in_stall,
	input  bwsu_pkg::req_t in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output bwsu_pkg::rsp_t out_data
);
	import bwsu_pkg::*;

	ctl_t ctl;
	sts_t sts;

	// sequencing
	bwsu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	// segment, base and scanner
	bwsu_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (in_data),
		.ctl       (ctl),
		.sts       (sts),
		.rsp       (out_data)
	);

endmodule

// ----- design/bwsu_datapath.sv -----
// bwsu_datapath: segment register, base register, bit-op decode and
// the bit-serial search scanner; depends on bwsu_pkg

module bwsu_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [31:0]     cfg_wdata,
	input  bwsu_pkg::req_t  req,
	input  bwsu_pkg::ctl_t  ctl,
	output bwsu_pkg::sts_t  sts,
	output bwsu_pkg::rsp_t  rsp
);
	import bwsu_pkg::*;

	logic [31:0]          base_q;
	logic [WORD_BITS-1:0] seg_q;
	logic [WORD_BITS-1:0] seg_nx;

	logic [32:0]          diff33;
	logic [31:0]          diff;
	logic [31:0]          lim32;
	logic                 gt;
	logic                 in_win;
	logic [LPW-1:0]       bidx_l;
	logic [WORD_BITS-1:0] onehot;
	logic                 hit_bit;
	logic [WORD_BITS-1:0] sub_m;

	rsp_t                 imm;
	logic                 need;
	logic [LPW-1:0]       sp;
	logic                 up;
	logic                 nth;

	logic [LPW-1:0]       p_q;
	logic [LPW-1:0]       cnt_q;
	logic [31:0]          n_q;
	logic                 up_q;
	logic                 nth_q;
	logic [31:0]          res_q;
	rsp_t                 rsp_q;

	logic [LPW-1:0]       sidx_l;
	logic                 sbit;
	logic [LPW-1:0]       cnt_nx;
	logic                 shit;
	logic                 sdone;
	logic [31:0]          found;

	// window check against the base register
	assign diff33 = {1'b0, req.position} - {1'b0, base_q};
	assign diff   = diff33[31:0];
	assign gt     = !diff33[32] && (diff != 32'd0);
	assign in_win = gt && (diff <= 32'(WORD_BITS));
	assign lim32  = diff - 32'd1;

	// local position 1 is the msb
	assign bidx_l  = WB_L - diff[LPW-1:0];
	assign onehot  = in_win ? ({{(WORD_BITS-1){1'b0}}, 1'b1} << bidx_l[IDXW-1:0])
		: '0;
	assign hit_bit = |(seg_q & onehot);
	assign sub_m   = seg_q & req.other_word[WORD_BITS-1:0];

	// command decode: immediate result, next segment and scan set-up
	always_comb begin
		seg_nx = seg_q;
		imm    = '0;
		need   = 1'b0;
		sp     = LPW'(1);
		up     = 1'b1;
		nth    = 1'b0;
		unique case (req.cmd)
			CMD_SET: begin
				if (in_win) begin
					seg_nx = seg_q | onehot;
				end else begin
					imm.range_error = 1'b1;
				end
			end
			CMD_CLR: begin
				if (hit_bit) begin
					seg_nx   = seg_q & ~onehot;
					imm.flag = 1'b1;
				end
			end
			CMD_TEST: begin
				imm.flag = hit_bit;
			end
			CMD_NEXT: begin
				need = !(gt && (diff >= 32'(WORD_BITS)));
				sp   = gt ? (diff[LPW-1:0] + LPW'(1)) : LPW'(1);
			end
			CMD_PRIOR: begin
				need = gt && (diff != 32'd1);
				sp   = (lim32 > 32'(WORD_BITS)) ? WB_L : lim32[LPW-1:0];
				up   = 1'b0;
			end
			CMD_NTH: begin
				need = (req.position != 32'd0);
				nth  = 1'b1;
			end
			CMD_SUB: begin
				if ((req.other_base == base_q) && (|sub_m)) begin
					seg_nx   = seg_q ^ sub_m;
					imm.flag = 1'b1;
				end
			end
			CMD_RSVD: begin
			end
			default: begin
			end
		endcase
	end

	// one local position per scan step
	assign sidx_l = WB_L - p_q;
	assign sbit   = seg_q[sidx_l[IDXW-1:0]];
	assign cnt_nx = cnt_q + LPW'(sbit);
	assign shit   = sbit && (!nth_q || ({{(32-LPW){1'b0}}, cnt_nx} == n_q));
	assign sdone  = shit || (up_q ? (p_q == WB_L) : (p_q == LPW'(1)));
	assign found  = base_q + {{(32-LPW){1'b0}}, p_q};

	assign sts.need_scan = need;
	assign sts.scan_done = sdone;
	assign rsp           = rsp_q;

	// base and segment state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			seg_q  <= '0;
		end else begin
			if (cfg_we) begin
				base_q <= cfg_wdata;
			end
			if (ctl.exec) begin
				seg_q <= seg_nx;
			end
		end
	end

	// scanner registers
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			p_q   <= sp;
			cnt_q <= '0;
			n_q   <= req.position;
			up_q  <= up;
			nth_q <= nth;
		end else if (ctl.step) begin
			p_q   <= up_q ? (p_q + LPW'(1)) : (p_q - LPW'(1));
			cnt_q <= cnt_nx;
			if (sdone) begin
				res_q <= shit ? found : 32'd0;
			end
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			rsp_q <= imm;
		end else if (ctl.load_res) begin
			rsp_q.found_index <= res_q;
			rsp_q.flag        <= 1'b0;
			rsp_q.range_error <= 1'b0;
		end
	end

endmodule

// ----- design/bwsu_ctrl.sv -----
// bwsu_ctrl: sequencing of requests, scan steps and the response register
// valid; depends on bwsu_pkg

module bwsu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  bwsu_pkg::sts_t sts,
	output bwsu_pkg::ctl_t ctl
);
	import bwsu_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;

	// response register free when empty or being taken
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE) || !out_free;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	// datapath commands
	assign ctl.exec     = accept && !sts.need_scan;
	assign ctl.start    = accept && sts.need_scan;
	assign ctl.step     = (state_q == ST_SCAN);
	assign ctl.load_res = (state_q == ST_FINISH) && out_free;

	// state and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (ctl.start) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (sts.scan_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (ctl.exec || ctl.load_res) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// a search that needs scanning enters the scan state
	a_start_scan: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |=> (state_q == ST_SCAN))
		else $error("scan start did not enter scan state");

	// the last scan step moves to finish
	a_scan_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.step && sts.scan_done) |=> (state_q == ST_FINISH))
		else $error("scan end did not reach finish");

	// a response is only loaded into a free register
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.exec || ctl.load_res) |-> out_free)
		else $error("response register overwritten");

	// a loaded response is shown next cycle
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.exec || ctl.load_res) |=> out_valid_q)
		else $error("loaded response not valid");

endmodule

// ----- bench/bitmap_word_search_unit_top_test.sv -----
`timescale 1ns / 100ps
// Testbench for bitmap_word_search_unit_top: directed and random requests are checked
// against an in-bench model of the 64-bit segment, under several idling patterns.
// Depends on bwsu_pkg and the bitmap_word_search_unit_top RTL.

module bitmap_word_search_unit_top_test;
	import bwsu_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 1_000_000;
	localparam int unsigned SETTLE_CYCLES = 80;
	localparam logic [31:0] BASE_TOP      = 32'hFFFF_FFC0;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	req_t        in_data;
	logic        out_valid;
	logic        out_stall = 1'b0;
	rsp_t        out_data;

	// predicted segment contents and base, plus responses still owed by the unit
	logic [63:0] seg_bits;
	logic [31:0] seg_base;
	rsp_t        owed_responses[$];

	int unsigned sender_idle_pct;
	int unsigned receiver_stall_pct;
	int unsigned cycle_count;
	int unsigned mismatch_count;
	int unsigned request_count;
	int unsigned response_count;
	int unsigned search_hits;
	int unsigned base_settings;

	bitmap_word_search_unit_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$error("run exceeded %0d cycles with %0d responses owed", CYCLE_LIMIT,
				owed_responses.size());
			$display("FAILURE");
			$finish;
		end
	end

	// response side: random stall and field-by-field comparison
	always @(posedge clk) begin : response_check
		rsp_t want;
		out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
		if (arst_n && out_valid && !out_stall) begin
			response_count++;
			if (owed_responses.size() == 0) begin
				$error("response with no request outstanding: found_index %0d", out_data.found_index);
				mismatch_count++;
			end else begin
				want = owed_responses.pop_front();
				if (want.found_index != 0)
					search_hits++;
				if (out_data.found_index !== want.found_index) begin
					$error("found_index: expected %0d, got %0d", want.found_index,
						out_data.found_index);
					mismatch_count++;
				end
				if (out_data.flag !== want.flag) begin
					$error("flag: expected %0b, got %0b", want.flag, out_data.flag);
					mismatch_count++;
				end
				if (out_data.range_error !== want.range_error) begin
					$error("range_error: expected %0b, got %0b", want.range_error,
						out_data.range_error);
					mismatch_count++;
				end
			end
		end
	end

	// segment model: applies one request and returns the response it owes
	function automatic rsp_t apply_request(input req_t req);
		rsp_t        rsp;
		logic [63:0] pos;
		logic [63:0] lo;
		logic [63:0] off;
		logic [63:0] lim;
		logic [63:0] taken;
		logic        in_win;
		logic        hit;
		int          p;
		int unsigned seen;
		rsp    = '0;
		pos    = 64'(req.position);
		lo     = 64'(seg_base);
		in_win = (pos > lo) && (pos - lo <= 64);
		off    = pos - lo;
		hit    = 1'b0;
		seen   = 0;
		case (req.cmd)
			CMD_SET: begin
				if (in_win)
					seg_bits[64 - off] = 1'b1;
				else
					rsp.range_error = 1'b1;
			end
			CMD_CLR: begin
				if (in_win) begin
					if (seg_bits[64 - off]) begin
						seg_bits[64 - off] = 1'b0;
						rsp.flag = 1'b1;
					end
				end
			end
			CMD_TEST: begin
				if (in_win)
					rsp.flag = seg_bits[64 - off];
			end
			CMD_NEXT: begin
				// start at or before the base scans the whole segment
				if (pos <= lo)
					off = 0;
				if (off < 64) begin
					for (p = int'(off) + 1; p <= 64 && !hit; p++) begin
						if (seg_bits[64 - p]) begin
							hit = 1'b1;
							rsp.found_index = seg_base + 32'(p);
						end
					end
				end
			end
			CMD_PRIOR: begin
				// start beyond the window scans the whole segment
				if (pos > lo) begin
					lim = (off - 1 > 64) ? 64'd64 : off - 1;
					for (p = int'(lim); p >= 1 && !hit; p--) begin
						if (seg_bits[64 - p]) begin
							hit = 1'b1;
							rsp.found_index = seg_base + 32'(p);
						end
					end
				end
			end
			CMD_NTH: begin
				if (req.position != 0) begin
					for (p = 1; p <= 64 && !hit; p++) begin
						if (seg_bits[64 - p]) begin
							seen++;
							if (seen == req.position) begin
								hit = 1'b1;
								rsp.found_index = seg_base + 32'(p);
							end
						end
					end
				end
			end
			CMD_SUB: begin
				if (req.other_base == seg_base) begin
					taken = seg_bits & req.other_word;
					if (taken != 0) begin
						seg_bits ^= taken;
						rsp.flag = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		return rsp;
	endfunction

	function automatic req_t make_request(input cmd_t cmd, input logic [31:0] position,
		input logic [63:0] other_word, input logic [31:0] other_base);
		req_t req;
		req.cmd        = cmd;
		req.position   = position;
		req.other_word = other_word;
		req.other_base = other_base;
		return req;
	endfunction

	// random request, mostly aimed at the window and the current base
	function automatic req_t random_request();
		req_t        req;
		int unsigned pick;
		pick           = $urandom_range(0, 99);
		req.other_word = {$urandom, $urandom};
		req.other_base = seg_base;
		case ($urandom_range(0, 9))
			0: req.position = $urandom;
			1: req.position = seg_base - $urandom_range(0, 3);
			default: req.position = seg_base + $urandom_range(0, 66);
		endcase
		if (pick < 30)
			req.cmd = CMD_SET;
		else if (pick < 42)
			req.cmd = CMD_CLR;
		else if (pick < 52)
			req.cmd = CMD_TEST;
		else if (pick < 64)
			req.cmd = CMD_NEXT;
		else if (pick < 76)
			req.cmd = CMD_PRIOR;
		else if (pick < 86) begin
			req.cmd = CMD_NTH;
			if ($urandom_range(0, 9) != 0)
				req.position = $urandom_range(0, 66);
		end else if (pick < 96) begin
			req.cmd = CMD_SUB;
			if ($urandom_range(0, 7) == 0)
				req.other_base = $urandom;
			else if ($urandom_range(0, 1) == 0)
				req.other_word = req.other_word & {$urandom, $urandom};
		end else
			req.cmd = cmd_t'($urandom_range(0, 7));
		return req;
	endfunction

	// send one request, with an optional idle gap before it
	task automatic send_request(input req_t req);
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do @(posedge clk); while (in_stall);
		owed_responses.push_back(apply_request(req));
		request_count++;
	endtask

	// hold off until every owed response has come back
	task automatic drain_requests();
		in_valid <= 1'b0;
		do @(posedge clk); while (owed_responses.size() != 0);
	endtask

	// base register write, only with the unit idle
	task automatic write_base(input logic [31:0] value);
		drain_requests();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		seg_base   = value;
		@(posedge clk);
		cfg_we <= 1'b0;
		base_settings++;
	endtask

	// set, test and clear at the window edges and outside it, base zero
	task automatic test_bit_ops();
		send_request(make_request(CMD_SET, 32'd1, '0, '0));
		send_request(make_request(CMD_SET, 32'd64, '0, '0));
		send_request(make_request(CMD_SET, 32'd0, '0, '0));
		send_request(make_request(CMD_SET, 32'hFFFF_FFFF, '0, '0));
		send_request(make_request(CMD_TEST, 32'd1, '0, '0));
		send_request(make_request(CMD_TEST, 32'd65, '0, '0));
		send_request(make_request(CMD_CLR, 32'd64, '0, '0));
		send_request(make_request(CMD_CLR, 32'd64, '0, '0));
		// next from the window's last position, prior from beyond it
		send_request(make_request(CMD_NEXT, 32'd64, '0, '0));
		send_request(make_request(CMD_PRIOR, 32'd200, '0, '0));
	endtask

	// searches around the highest base
	task automatic test_searches();
		send_request(make_request(CMD_SET, BASE_TOP + 32'd1, '0, '0));
		send_request(make_request(CMD_SET, 32'hFFFF_FFFF, '0, '0));
		send_request(make_request(CMD_NEXT, 32'd0, '0, '0));
		send_request(make_request(CMD_NEXT, BASE_TOP + 32'd1, '0, '0));
		send_request(make_request(CMD_PRIOR, BASE_TOP, '0, '0));
		send_request(make_request(CMD_PRIOR, BASE_TOP + 32'd5, '0, '0));
		send_request(make_request(CMD_NTH, 32'd0, '0, '0));
		send_request(make_request(CMD_NTH, 32'd2, '0, '0));
		send_request(make_request(CMD_NTH, 32'hFFFF_FFFF, '0, '0));
	endtask

	// subtract with matching and foreign base, then the unused command
	task automatic test_subtract();
		send_request(make_request(CMD_SUB, '0, 64'h8000_0000_0000_0000, seg_base));
		send_request(make_request(CMD_SUB, '0, 64'h8000_0000_0000_0000, seg_base));
		send_request(make_request(CMD_SUB, '0, '1, 32'hFFFF_FFFF));
		send_request(make_request(CMD_SUB, '0, '1, seg_base));
		send_request(make_request(CMD_RSVD, '1, '1, '1));
	endtask

	// random phase at one base with one idling pattern, held once halfway
	task automatic test_random(input logic [31:0] base, input int unsigned idle_pct,
		input int unsigned stall_pct, input int unsigned count);
		write_base(base);
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		for (int unsigned i = 0; i < count; i++) begin
			if (i == count / 2)
				drain_requests();
			send_request(random_request());
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		seg_bits           = '0;
		seg_base           = '0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_bit_ops();
		write_base(BASE_TOP);
		test_searches();
		test_subtract();
		test_random(32'd0, 0, 0, 300);
		test_random($urandom_range(0, BASE_TOP), 83, 0, 300);
		test_random(BASE_TOP, 0, 83, 300);
		test_random($urandom_range(0, BASE_TOP), 31, 31, 300);

		// let the last responses come back, then allow for a full search
		drain_requests();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d requests over %0d base settings, %0d responses compared",
			request_count, base_settings + 1, response_count);
		$display("%0d searches returned an index, %0d mismatches", search_hits,
			mismatch_count);
		if (mismatch_count == 0 && owed_responses.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
